@@ hw/rtl/terrain_vertex_quantizer_core_defines.svh @@
// Assertion macros shared by the vertex quantizer RTL.
`ifndef TERRAIN_VERTEX_QUANTIZER_CORE_DEFINES_SVH
`define TERRAIN_VERTEX_QUANTIZER_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TVQ_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Implication checked in the cycle after the condition.
`define TVQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ hw/rtl/tvq_pkg.sv @@
package tvq_pkg;

   localparam int unsigned FLOAT_W  = 32;
   localparam int unsigned SHIFT_W  = 4;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;
   localparam logic [0:0] REG_SCALE_SHIFT = 1'b0;

   typedef enum logic [1:0] {
      MODE_POS = 2'b01,
      MODE_TEX = 2'b10
   } scale_mode_type;

   typedef struct packed {
      logic        chunk_start;
      logic [7:0]  occlusion_in;
      logic [7:0]  light_in;
      logic [15:0] state_bits_in;
      logic [15:0] voxel_type_in;
      logic [31:0] normal_z;
      logic [31:0] normal_y;
      logic [31:0] normal_x;
      logic [63:0] uv_pair;
      logic [31:0] pos_z;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         corner;
      logic [7:0]         occlusion_out;
      logic [7:0]         light_out;
      logic [15:0]        state_bits_out;
      logic [15:0]        voxel_type_out;
      logic signed [7:0]  snorm_z;
      logic signed [7:0]  snorm_y;
      logic signed [7:0]  snorm_x;
      logic [31:0]        uv_fixed;
      logic signed [15:0] fixed_z;
      logic signed [15:0] fixed_y;
      logic signed [15:0] fixed_x;
   } rsp_payload_type;

endpackage

@@ hw/rtl/tvq_scale_lane.sv @@
// One position or texture lane: x * 2^shift, rounded half away from zero,
// saturated to the lane's range. Scaling by a power of two is exact in
// float, except where it overflows to infinity, which saturates anyway.
module tvq_scale_lane
   import tvq_pkg::*;
(
   input  logic [FLOAT_W-1:0] bits,
   input  logic [SHIFT_W-1:0] shift,
   input  scale_mode_type     mode,
   output logic [15:0]        result
);
   logic        sgn;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic [23:0] mant;
   logic        is_nan;
   logic [9:0]  e_eff;
   logic [40:0] shifted;
   logic [17:0] mag;
   logic        big;

   always_comb begin
      sgn    = bits[31];
      expo   = bits[30:23];
      frac   = bits[22:0];
      is_nan = (expo == 8'hFF) && (frac != 23'd0);
      mant   = {(expo != 8'd0), frac};
      // Biased exponent plus shift, so that e_eff == 127 means 2^0.
      e_eff  = {2'b00, expo} + {6'd0, shift};
      big    = (expo == 8'hFF) || (e_eff >= 10'd144);
      shifted = 41'd0;
      mag     = 18'd0;
      if (!big && e_eff >= 10'd126) begin
         // value = mant * 2^(e_eff-150); keep one fraction bit for rounding.
         shifted = {17'd0, mant} << (e_eff - 10'd126);
         mag     = shifted[41-1:24] + {17'd0, shifted[23]};
      end
      if (e_eff < 10'd126 || expo == 8'd0) begin
         mag = 18'd0;
      end
      if (expo == 8'd0) begin
         mag = 18'd0;
      end
      result = 16'd0;
      unique case (mode)
         MODE_POS: begin
            if (is_nan) result = 16'd0;
            else if (!sgn) result = (big || mag >= 18'd32767) ? 16'h7FFF : mag[15:0];
            else if (big || mag >= 18'd32768) result = 16'h8000;
            else result = 16'(-mag[15:0]);
         end
         MODE_TEX: begin
            if (is_nan || sgn) result = 16'd0;
            else result = (big || mag >= 18'd65535) ? 16'hFFFF : mag[15:0];
         end
         default: result = 16'd0;
      endcase
   end
endmodule

@@ hw/rtl/tvq_snorm_lane.sv @@
// One normal lane: clamp to [-1,1], times 127 rounded to nearest even in
// single precision, then rounded half away from zero. The exact product
// mant*127 has 30 or 31 bits, so it is first rounded back to a 24-bit
// significand. That step can lift a product lying just below a half-point
// onto it, so the integer rounding works on the rounded product.
module tvq_snorm_lane
   import tvq_pkg::*;
(
   input  logic [FLOAT_W-1:0] bits,
   output logic [7:0]         result
);
   logic        sgn;
   logic [7:0]  expo;
   logic [23:0] mant;
   logic [30:0] prod;
   logic [24:0] kept;
   logic        rnd_bit;
   logic        sticky;
   logic [31:0] prod_r;
   logic [55:0] fixed_v;
   logic [7:0]  mag;
   logic [7:0]  sh;

   always_comb begin
      sgn  = bits[31];
      expo = bits[30:23];
      mant = {(expo != 8'd0), bits[22:0]};
      prod = 31'(mant) * 31'd127;
      // Round the product to 24 significant bits, ties to even.
      if (prod[30]) begin
         kept    = {1'b0, prod[30:7]};
         rnd_bit = prod[6];
         sticky  = |prod[5:0];
      end else begin
         kept    = {1'b0, prod[29:6]};
         rnd_bit = prod[5];
         sticky  = |prod[4:0];
      end
      kept   = kept + {24'd0, rnd_bit & (sticky | kept[0])};
      prod_r = prod[30] ? {kept, 7'd0} : {1'b0, kept, 6'd0};
      fixed_v = 56'd0;
      mag  = 8'd0;
      sh   = 8'd0;
      if (expo == 8'hFF && bits[22:0] != 23'd0) begin
         mag = 8'd0;
      end else if (expo >= 8'd127) begin
         mag = 8'd127;
      end else if (expo >= 8'd100) begin
         // x*127 = prod_r * 2^(expo-150); after the shift fixed_v holds it
         // with 24 fraction bits.
         sh = 8'd126 - expo;
         fixed_v = {24'd0, prod_r} >> sh;
         mag = 8'(fixed_v[55:24] + {31'd0, fixed_v[23]});
      end
      result = sgn ? 8'(-mag) : mag;
   end
endmodule

@@ hw/rtl/terrain_vertex_quantizer_core.sv @@
// Terrain vertex quantizer.
// Input channel req_*: one vertex per item (float position, uv pair, normal
// and pass-through voxel fields). Result channel rsp_*: one quantized vertex
// per item. Both use valid/ready; an item moves when valid and ready are high.
// Configuration: APB-style csr_* port; register 0 (byte address 0) holds
// scale_shift, the log2 of the position and uv scale (reset value 8).
// An item accepted in one cycle is offered on rsp_* in the next, from the
// output register. Throughput is one item per cycle unless rsp_ready
// stalls; eight lanes (three position, two uv and three normal) work in
// parallel beside the copy path; a merge stage packs all into that register.
// When the receiver stalls, the output register holds the item; req_ready
// stays high whenever that register is empty or is being drained this cycle.
// Synchronous reset empties the output register, clears the corner counter
// and loads scale_shift with 8.
// The corner counter numbers vertices modulo four and restarts at zero on
// an item carrying chunk_start.
module terrain_vertex_quantizer_core
   import tvq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);
`include "terrain_vertex_quantizer_core_defines.svh"

   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [1:0]         corner_ff, corner_in;
   logic               valid_ff, valid_in;
   rsp_payload_type    data_ff, data_in;
   logic               take;
   logic [1:0]         corner_now;
   logic [15:0]        px, py, pz, tu, tv;
   logic [7:0]         nx, ny, nz;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SCALE_SHIFT)
                       ? {28'd0, shift_ff} : 32'd0;

   always_comb begin
      shift_in = shift_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_SCALE_SHIFT) begin
         shift_in = csr_pwdata[SHIFT_W-1:0];
      end
   end

   tvq_scale_lane u_px (.bits(req_data.pos_x), .shift(shift_ff), .mode(MODE_POS), .result(px));
   tvq_scale_lane u_py (.bits(req_data.pos_y), .shift(shift_ff), .mode(MODE_POS), .result(py));
   tvq_scale_lane u_pz (.bits(req_data.pos_z), .shift(shift_ff), .mode(MODE_POS), .result(pz));
   tvq_scale_lane u_tu (.bits(req_data.uv_pair[31:0]), .shift(shift_ff), .mode(MODE_TEX),
                        .result(tu));
   tvq_scale_lane u_tv (.bits(req_data.uv_pair[63:32]), .shift(shift_ff), .mode(MODE_TEX),
                        .result(tv));
   tvq_snorm_lane u_nx (.bits(req_data.normal_x), .result(nx));
   tvq_snorm_lane u_ny (.bits(req_data.normal_y), .result(ny));
   tvq_snorm_lane u_nz (.bits(req_data.normal_z), .result(nz));

   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign corner_now = req_data.chunk_start ? 2'd0 : corner_ff;

   // Merge stage: pack all lane results into the output register.
   always_comb begin
      valid_in  = valid_ff;
      corner_in = corner_ff;
      data_in   = data_ff;
      if (rsp_ready) valid_in = 1'b0;
      if (take) begin
         valid_in  = 1'b1;
         corner_in = corner_now + 2'd1;
         data_in.fixed_x        = px;
         data_in.fixed_y        = py;
         data_in.fixed_z        = pz;
         data_in.uv_fixed       = {tv, tu};
         data_in.snorm_x        = nx;
         data_in.snorm_y        = ny;
         data_in.snorm_z        = nz;
         data_in.voxel_type_out = req_data.voxel_type_in;
         data_in.state_bits_out = req_data.state_bits_in;
         data_in.light_out      = req_data.light_in;
         data_in.occlusion_out  = req_data.occlusion_in;
         data_in.corner         = corner_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         corner_ff <= 2'd0;
         shift_ff  <= SHIFT_RESET;
      end else begin
         valid_ff  <= valid_in;
         corner_ff <= corner_in;
         shift_ff  <= shift_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `TVQ_ASSERT_NEXT(a_take_valid, clock, reset, take, rsp_valid,
      "accepted item not offered")
   `TVQ_ASSERT_NEXT(a_corner_adv, clock, reset, take, corner_ff == rsp_data.corner + 2'd1,
      "corner counter out of step")
   `TVQ_ASSERT_IMP(a_ready_free, clock, reset, !rsp_valid, req_ready,
      "input stalled with empty output")
endmodule

@@ sim/testbench.sv @@
`default_nettype none

// Scoreboard for the vertex quantizer. It keeps its own copy of the scale
// register and the corner counter, works out each quantized vertex when an
// input vertex is accepted, and checks the results in order.
class vertex_scoreboard;
   tvq_pkg::rsp_payload_type expected_vertices[$];
   logic [3:0] scale_shift;
   logic [1:0] corner_count;
   int         mismatches;
   int         checked;

   function new();
      scale_shift  = tvq_pkg::SHIFT_RESET;
      corner_count = 2'd0;
      mismatches   = 0;
      checked      = 0;
   endfunction

   // Magnitude of a finite float as a real value, exact.
   static function real float_magnitude(logic [31:0] bits);
      int unsigned mant;
      int          expo;
      mant = (bits[30:23] == 8'd0) ? bits[22:0] : (bits[22:0] | 32'h0080_0000);
      expo = (bits[30:23] == 8'd0) ? 1 : bits[30:23];
      return real'(mant) * (2.0 ** (expo - 150));
   endfunction

   // Round half away from zero for values well inside the int range.
   static function int round_half_away(real x);
      real a;
      int  n;
      a = (x < 0.0) ? -x : x;
      n = $rtoi(a);
      if (a - real'(n) >= 0.5) n++;
      return (x < 0.0) ? -n : n;
   endfunction

   function logic [15:0] quantize_position(logic [31:0] bits);
      real x;
      if (bits[30:23] == 8'hFF) begin
         if (bits[22:0] != 23'd0) return 16'h0000;
         return bits[31] ? 16'h8000 : 16'h7FFF;
      end
      x = float_magnitude(bits) * (2.0 ** scale_shift);
      if (bits[31]) x = -x;
      if (x >= 32767.0) return 16'h7FFF;
      if (x <= -32768.0) return 16'h8000;
      return 16'(round_half_away(x));
   endfunction

   function logic [15:0] quantize_texcoord(logic [31:0] bits);
      real x;
      if (bits[30:23] == 8'hFF && bits[22:0] != 23'd0) return 16'h0000;
      if (bits[31] || bits[30:0] == 31'd0) return 16'h0000;
      if (bits[30:23] == 8'hFF) return 16'hFFFF;
      x = float_magnitude(bits) * (2.0 ** scale_shift);
      if (x >= 65535.0) return 16'hFFFF;
      return 16'(round_half_away(x));
   endfunction

   // The normal is clamped, multiplied by 127 and the product rounded to
   // single precision (nearest even), all in integer arithmetic so that the
   // final half-away rounding sees exactly the single-precision product.
   static function logic [7:0] quantize_normal(logic [31:0] bits);
      longint unsigned prod;
      longint unsigned dropped;
      longint unsigned half;
      int              expo;
      int              len;
      int              sh;
      int              n;
      if (bits[30:23] == 8'hFF && bits[22:0] != 23'd0) return 8'h00;
      if (bits[30:0] > 31'h3F80_0000) begin
         n = 127;
      end else begin
         prod = longint'((bits[30:23] == 8'd0) ? bits[22:0] : (bits[22:0] | 32'h0080_0000));
         prod = prod * 127;
         expo = (bits[30:23] == 8'd0) ? 1 : bits[30:23];
         sh   = 150 - expo;
         len  = 0;
         while ((prod >> len) != 0) len++;
         if (len > 24) begin
            dropped = prod & ((64'd1 << (len - 24)) - 1);
            half    = 64'd1 << (len - 25);
            prod    = prod >> (len - 24);
            if (dropped > half || (dropped == half && prod[0])) prod++;
            sh = sh - (len - 24);
         end
         if (sh > 62) n = 0;
         else if (sh <= 0) n = int'(prod << (-sh));
         else n = int'(prod >> sh) + int'((prod >> (sh - 1)) & 1);
      end
      return 8'(bits[31] ? -n : n);
   endfunction

   function void note_vertex(tvq_pkg::req_payload_type v);
      tvq_pkg::rsp_payload_type q;
      if (v.chunk_start) corner_count = 2'd0;
      q.fixed_x        = quantize_position(v.pos_x);
      q.fixed_y        = quantize_position(v.pos_y);
      q.fixed_z        = quantize_position(v.pos_z);
      q.uv_fixed       = {quantize_texcoord(v.uv_pair[63:32]),
                          quantize_texcoord(v.uv_pair[31:0])};
      q.snorm_x        = quantize_normal(v.normal_x);
      q.snorm_y        = quantize_normal(v.normal_y);
      q.snorm_z        = quantize_normal(v.normal_z);
      q.voxel_type_out = v.voxel_type_in;
      q.state_bits_out = v.state_bits_in;
      q.light_out      = v.light_in;
      q.occlusion_out  = v.occlusion_in;
      q.corner         = corner_count;
      corner_count     = corner_count + 2'd1;
      expected_vertices.insert(expected_vertices.size(), q);
   endfunction

   function void compare_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   function void check_vertex(tvq_pkg::rsp_payload_type got);
      tvq_pkg::rsp_payload_type q;
      if (expected_vertices.size() == 0) begin
         $error("quantized vertex arrived with none outstanding");
         mismatches++;
         return;
      end
      q = expected_vertices.pop_front();
      checked++;
      compare_field("fixed_x", q.fixed_x, got.fixed_x);
      compare_field("fixed_y", q.fixed_y, got.fixed_y);
      compare_field("fixed_z", q.fixed_z, got.fixed_z);
      compare_field("uv_fixed", q.uv_fixed, got.uv_fixed);
      compare_field("snorm_x", q.snorm_x, got.snorm_x);
      compare_field("snorm_y", q.snorm_y, got.snorm_y);
      compare_field("snorm_z", q.snorm_z, got.snorm_z);
      compare_field("voxel_type_out", q.voxel_type_out, got.voxel_type_out);
      compare_field("state_bits_out", q.state_bits_out, got.state_bits_out);
      compare_field("light_out", q.light_out, got.light_out);
      compare_field("occlusion_out", q.occlusion_out, got.occlusion_out);
      compare_field("corner", q.corner, got.corner);
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tvq_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AT_RESULT = 700;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [2:0]      csr_paddr;
   logic [31:0]     csr_pwdata;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   vertex_scoreboard vertex_board;
   int               results_seen;
   int               vertices_sent;
   int               idle_cycles;
   bit               no_idling;
   bit               hold_done;

   // A handful of float bit patterns that sit on the edges of the encoders:
   // zeros, unit values, infinities, NaNs, denormals, the saturation limits
   // and values that land exactly on a half after scaling.
   logic [31:0] edge_floats[18] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h7F7F_FFFF, 32'h3F00_0000, 32'hBF00_0000,
      32'h4700_0000, 32'hC700_0000, 32'h3B00_0000, 32'hBB00_0000,
      32'h4000_0000, 32'h477F_FF00
   };

   terrain_vertex_quantizer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A float drawn from a chosen exponent window most of the time, so that
   // values fall where rounding and saturation happen; the rest are raw bits
   // or one of the edge patterns.
   function automatic logic [31:0] draw_float(int lo_exp, int hi_exp);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom();
      if (pick == 1) return edge_floats[$urandom_range(0, 17)];
      return {1'($urandom()), 8'($urandom_range(lo_exp, hi_exp)), 23'($urandom())};
   endfunction

   function automatic req_payload_type draw_vertex();
      req_payload_type v;
      v.pos_x         = draw_float(100, 150);
      v.pos_y         = draw_float(100, 150);
      v.pos_z         = draw_float(100, 150);
      v.uv_pair       = {draw_float(100, 150), draw_float(100, 150)};
      v.normal_x      = draw_float(110, 127);
      v.normal_y      = draw_float(110, 127);
      v.normal_z      = draw_float(110, 127);
      v.voxel_type_in = 16'($urandom());
      v.state_bits_in = 16'($urandom());
      v.light_in      = 8'($urandom());
      v.occlusion_in  = 8'($urandom());
      v.chunk_start   = ($urandom_range(0, 5) == 0);
      return v;
   endfunction

   // Offer one vertex, after a random gap unless idling is switched off, and
   // return at the edge where it is accepted. Valid is only lowered when a
   // gap follows, so back-to-back items keep it high.
   task automatic send_vertex(input req_payload_type v);
      int gap;
      gap = no_idling ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do @(posedge clock); while (!req_ready);
      vertex_board.note_vertex(v);
      vertices_sent++;
   endtask

   // Two-phase register write. It is only called while the block is idle;
   // the scoreboard copy changes only when the write index is a real register.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      req_valid   <= 1'b0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == {REG_SCALE_SHIFT, 2'b00}) vertex_board.scale_shift = value[3:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Wait until every expected vertex has come back through the single output
   // stage, then let the clock run on with req_valid low.
   task automatic drain();
      req_valid <= 1'b0;
      while (vertex_board.expected_vertices.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_vertex(draw_vertex());
   endtask

   // Result side: a random stall before each item unless idling is off, and
   // once, well into the run, a long hold-off so the output stage fills and
   // req_ready drops while the sender keeps offering vertices.
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = no_idling ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         vertex_board.check_vertex(rsp_data);
         results_seen++;
      end
   end

   // Watchdog: counts cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_payload_type v;
      vertex_board  = new();
      results_seen  = 0;
      vertices_sent = 0;
      no_idling     = 1'b0;
      hold_done     = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at scale 256 (reset): the fields walk the edge patterns
      // from different offsets, with pos_x and normal_x sharing one; pass-through
      // fields hit all-zeros and all-ones, and chunk starts fall mid-count.
      for (int i = 0; i < 20; i++) begin
         v.pos_x         = edge_floats[i % 18];
         v.pos_y         = edge_floats[(i + 3) % 18];
         v.pos_z         = edge_floats[(i + 7) % 18];
         v.uv_pair       = {edge_floats[(i + 5) % 18], edge_floats[(i + 11) % 18]};
         v.normal_x      = edge_floats[i % 18];
         v.normal_y      = edge_floats[(i + 9) % 18];
         v.normal_z      = edge_floats[(i + 14) % 18];
         v.voxel_type_in = i[0] ? 16'hFFFF : 16'h0000;
         v.state_bits_in = i[0] ? 16'h0000 : 16'hFFFF;
         v.light_in      = i[1] ? 8'hFF : 8'h00;
         v.occlusion_in  = i[1] ? 8'h00 : 8'hFF;
         v.chunk_start   = (i == 6 || i == 7 || i == 13);
         send_vertex(v);
      end
      drain();

      // Scale extremes and a few settings between them. A write to the
      // address past the only register must leave the scale alone.
      write_register(3'd0, 32'd0);
      send_random(300);
      drain();
      write_register(3'd4, 32'd5);
      write_register(3'd0, 32'd15);
      send_random(300);
      drain();

      // A stretch with no idling on either side, which also carries the
      // long receiver hold-off.
      write_register(3'd0, 32'hFFFF_FFF3);
      no_idling = 1'b1;
      send_random(400);
      no_idling = 1'b0;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_register(3'd0, $urandom_range(1, 14));
         send_random(170);
         drain();
      end

      $display("Quantized %0d vertices (%0d checked) across scale settings 0 to 15,",
               vertices_sent, vertex_board.checked);
      $display("with edge floats, chunk restarts, random stalls and one long hold-off.");
      if (vertex_board.mismatches == 0 && vertex_board.expected_vertices.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
